// ===== rtl/adcsc_pkg.sv =====
// adcsc_pkg: types, codes and constants of the converter sample scaler
// used by adcsc_div, the top level and the checker; no dependencies

package adcsc_pkg;

  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned RAW_W  = 24;
  localparam int unsigned V_W    = 25;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned TOFF_W = 19;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned K_W    = 14;
  localparam int unsigned PROD_W = DIFF_W + K_W;
  localparam int unsigned NUM_W  = 46;
  localparam int unsigned DEN_W  = 32;

  localparam int unsigned S_TDATA_W = 120;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 4;

  localparam logic signed [V_W-1:0]    RAW_BIAS     = 25'sh7FFFFF;
  localparam logic signed [K_W-1:0]    SCALE_GAIN   = 14'sd6000;
  localparam logic signed [K_W-1:0]    TEMP_GAIN    = 14'sd872;
  localparam logic signed [DEN_W-1:0]  TEMP_DIV     = 32'sd100000;
  localparam logic signed [COEF_W-1:0] TEMP_BIAS    = 32'sd30647;
  localparam logic signed [COEF_W-1:0] SLOPE_RESET  = 32'sd4256000;
  localparam logic signed [COEF_W-1:0] OFFSET_RESET = 32'sh50000;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TEMP   = 2'd1,
    KIND_CAL    = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_SAT     = 3'd2,
    ST_IGNORED = 3'd3,
    ST_FAULT   = 3'd4
  } status_e;

  typedef enum logic {
    REG_FAULT = 1'b0,
    REG_TOFFS = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_START,
    S_DIV,
    S_POST,
    S_FIN
  } state_e;

endpackage

// ===== rtl/adc_sample_calibration_scaler_top.sv =====
// adc_sample_calibration_scaler_top: converter sample scaler with per-channel calibration
// depends on adcsc_pkg and adcsc_div
//
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata raw/ref/slope/offset, tuser kind/channel
// m_axis    out  tvalid/tready             tdata value, tuser channel/status
// apb       in   psel/penable/pready       device_fault at 0x0, temp_offset at 0x4
//
// samples, temperature and calibration with a reference use the multiplier and divider;
// the shared divider retires two quotient bits a cycle over 23 steps
// load, zero calibration, zero slope and device fault beats skip the multiply and divide
// one item in flight; a new beat is taken while a finished result waits on m_axis
// reset returns the coefficients to their defaults at once, no clearing pass

module adc_sample_calibration_scaler_top import adcsc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // raw_sample[23:0], reference_value[55:24], load_slope[87:56], load_offset[119:88]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind[1:0], channel[2]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // value[31:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // out_channel[0], status[3:1]
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh7FFFFFFF);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sh80000000);

  state_e state_q, state_d;

  logic                     fault_q;
  logic signed [TOFF_W-1:0] toff_q;

  logic signed [COEF_W-1:0] slope_q [CHANNELS];
  logic signed [COEF_W-1:0] offs_q  [CHANNELS];

  kind_e                    kind_q;
  logic                     ch_q;
  logic [IDX_W-1:0]         idx;
  logic signed [V_W-1:0]    v_q, v_d;
  logic signed [COEF_W-1:0] ref_q, lslope_q, loffs_q;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [DEN_W-1:0]  den_q, den_d;
  logic signed [PROD_W-1:0] num_q, prod;
  logic signed [K_W-1:0]    gain;
  logic                     neg_q;

  logic                     direct;
  logic signed [COEF_W-1:0] res_q, res_d, direct_res;
  status_e                  status_q, status_d, direct_status;

  logic                     div_start, div_done;
  logic [NUM_W-1:0]         num_mag, quotient;
  logic [DEN_W-1:0]         den_mag;
  logic signed [PROD_W-1:0] q_signed;

  logic                     out_valid_q;
  logic                     out_load;
  logic signed [COEF_W-1:0] out_value_q;
  logic                     out_ch_q;
  status_e                  out_status_q;

  logic                     cfg_we;
  logic [RAW_W-1:0]         raw;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= 1'b0;
      toff_q  <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        REG_FAULT: fault_q <= pwdata[0];
        REG_TOFFS: toff_q  <= pwdata[TOFF_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_FAULT: prdata = {31'd0, fault_q};
      REG_TOFFS: prdata = {{(32 - TOFF_W){1'b0}}, toff_q};
    endcase
  end

  // raw word decode, one off from two's complement
  assign raw = s_axis_tdata[RAW_W-1:0];
  always_comb begin
    if (raw[RAW_W-1]) begin
      v_d = $signed({2'b00, raw[RAW_W-2:0]}) - RAW_BIAS;
    end else begin
      v_d = $signed({1'b0, raw});
    end
  end

  assign idx = (CHANNELS > 1) ? IDX_W'(ch_q) : '0;

  // early results and divider operands
  always_comb begin
    direct        = 1'b0;
    direct_res    = '0;
    direct_status = ST_OK;
    diff_d        = $signed({{(DIFF_W - V_W){v_q[V_W-1]}}, v_q})
                  - $signed({offs_q[idx][COEF_W-1], offs_q[idx]});
    den_d         = slope_q[idx];
    if (fault_q) begin
      direct        = 1'b1;
      direct_status = ST_FAULT;
    end else begin
      unique case (kind_q)
        KIND_SAMPLE: begin
          if (slope_q[idx] == '0) begin
            direct        = 1'b1;
            direct_status = ST_DIV0;
          end
        end
        KIND_TEMP: begin
          diff_d = $signed({{(DIFF_W - V_W){v_q[V_W-1]}}, v_q})
                 + $signed({{(DIFF_W - TOFF_W){toff_q[TOFF_W-1]}}, toff_q});
          den_d  = TEMP_DIV;
        end
        KIND_CAL: begin
          den_d = ref_q;
          if (ref_q == '0) begin
            direct     = 1'b1;
            direct_res = $signed({{(COEF_W - V_W){v_q[V_W-1]}}, v_q});
          end
        end
        KIND_LOAD: begin
          direct = 1'b1;
          if (lslope_q == '0) begin
            direct_status = ST_IGNORED;
          end else begin
            direct_res = lslope_q;
          end
        end
      endcase
    end
  end

  assign gain = (kind_q == KIND_TEMP) ? TEMP_GAIN : SCALE_GAIN;
  assign prod = diff_q * gain;

  assign num_mag = num_q[PROD_W-1] ? NUM_W'(-num_q) : num_q[NUM_W-1:0];
  assign den_mag = den_q[DEN_W-1] ? DEN_W'(-den_q) : den_q;

  adcsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sign, clamp and temperature bias
  always_comb begin
    q_signed = neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    status_d = ST_OK;
    if (kind_q == KIND_TEMP) begin
      res_d = COEF_W'(q_signed) - TEMP_BIAS;
    end else if (q_signed > SAT_MAX) begin
      res_d    = SAT_MAX[COEF_W-1:0];
      status_d = ST_SAT;
    end else if (q_signed < SAT_MIN) begin
      res_d    = SAT_MIN[COEF_W-1:0];
      status_d = ST_SAT;
    end else begin
      res_d = COEF_W'(q_signed);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_PREP;
      S_PREP:  state_d = direct ? S_FIN : S_MUL;
      S_MUL:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_POST;
      S_POST:  state_d = S_FIN;
      S_FIN:   if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_START: div_start     = 1'b1;
      S_FIN:   out_load      = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slope_q[i] <= SLOPE_RESET;
        offs_q[i]  <= OFFSET_RESET;
      end
    end else if (state_q == S_PREP && !fault_q) begin
      if (kind_q == KIND_LOAD && lslope_q != '0) begin
        slope_q[idx] <= lslope_q;
        offs_q[idx]  <= loffs_q;
      end else if (kind_q == KIND_CAL && ref_q == '0) begin
        offs_q[idx] <= direct_res;
      end
    end else if (state_q == S_POST && kind_q == KIND_CAL) begin
      slope_q[idx] <= res_d;
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_q   <= kind_e'(s_axis_tuser[1:0]);
          ch_q     <= s_axis_tuser[2];
          v_q      <= v_d;
          ref_q    <= s_axis_tdata[55:24];
          lslope_q <= s_axis_tdata[87:56];
          loffs_q  <= s_axis_tdata[119:88];
        end
      end
      S_PREP: begin
        diff_q   <= diff_d;
        den_q    <= den_d;
        res_q    <= direct_res;
        status_q <= direct_status;
      end
      S_MUL:   num_q <= prod;
      S_START: neg_q <= num_q[PROD_W-1] ^ den_q[DEN_W-1];
      S_POST: begin
        res_q    <= res_d;
        status_q <= status_d;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= res_q;
      out_ch_q     <= ch_q;
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_status_q, out_ch_q};

endmodule

// ===== rtl/adcsc_div.sv =====
// adcsc_div: unsigned restoring divider, two quotient bits per cycle
// depends on adcsc_pkg for operand widths

module adcsc_div import adcsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned STEPS = NUM_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [NUM_W-1:0] a_q, a_d;
  logic [DEN_W-1:0] r_q, r_d;
  logic [DEN_W-1:0] d_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0]   r1, r2;
  logic [DEN_W+1:0] t1, t2;
  logic             b1, b2;
  logic [DEN_W-1:0] r1n;
  logic [NUM_W-1:0] a1;

  always_comb begin
    r1  = {r_q, a_q[NUM_W-1]};
    t1  = {1'b0, r1} - {2'b00, d_q};
    b1  = ~t1[DEN_W+1];
    r1n = b1 ? t1[DEN_W-1:0] : r1[DEN_W-1:0];
    a1  = {a_q[NUM_W-2:0], b1};
    r2  = {r1n, a1[NUM_W-1]};
    t2  = {1'b0, r2} - {2'b00, d_q};
    b2  = ~t2[DEN_W+1];
    r_d = b2 ? t2[DEN_W-1:0] : r2[DEN_W-1:0];
    a_d = {a1[NUM_W-2:0], b2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= a_d;
      r_q <= r_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = a_q;

endmodule

// ===== rtl/adcsc_chk.sv =====
// adcsc_chk: port-level checks on the converter sample scaler, bound to its top level
// depends on adcsc_pkg and adc_sample_calibration_scaler_top

module adcsc_chk import adcsc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("beat taken while an item is in flight");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[3:1] <= ST_FAULT)
    else $error("status code out of range");

  // error statuses carry a zero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[3:1] == ST_DIV0 || m_axis_tuser[3:1] == ST_IGNORED
      || m_axis_tuser[3:1] == ST_FAULT) |-> m_axis_tdata == '0)
    else $error("nonzero value with error status");

endmodule

bind adc_sample_calibration_scaler_top adcsc_chk u_adcsc_chk (.*);
